// ===== rtl/ipfa_pkg.sv =====
// ----------------------------------------------------------------------------
// ipfa_pkg
// shared constants, codes and control types of the id pool allocator
// ----------------------------------------------------------------------------
package ipfa_pkg;

   localparam int MAX_IDS    = 1024;
   localparam int COUNT_BITS = 32;
   localparam int ID_BITS    = 11;
   localparam int IDX_BITS   = $clog2(MAX_IDS);
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 48;
   localparam int RSP_CNT_BITS  = 32;

   localparam logic [ID_BITS-1:0]    NONE_ID   = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [1:0] MODE_ASSIGN  = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_COUNT   = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   typedef enum logic [2:0] {
      ST_ASSIGNED    = 3'd0,
      ST_EXHAUSTED   = 3'd1,
      ST_RELEASED    = 3'd2,
      ST_REL_IGNORED = 3'd3,
      ST_COUNTED     = 3'd4,
      ST_FALLBACK    = 3'd5
   } status_type;

   typedef struct packed {
      logic                accept;
      logic                exec;
      logic                load_rsp;
      logic                clear_en;
      logic [IDX_BITS-1:0] clear_addr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic no_result;
   } dp_status_type;

endpackage

// ===== rtl/id_pool_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// id_pool_free_list_allocator_core
// hands out, releases and reference-counts small integer ids from a pool
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the reference counter
// memory, one entry a cycle; req_tready stays low until it
// ends. For each request, the accept cycle reads the free
// list link at the current head and the counter of the requested id from
// their synchronous memories, and the execute cycle writes them back, moves the
// head or fresh counter and loads the response register. A result waits in
// that register while the next request is accepted; the execute cycle holds
// only when the previous result is still not taken. Assign pops the most
// recently released id, else the lowest never-used one, else reports
// exhausted with id -1. Mode 3 is accepted and gives no response.
module id_pool_free_list_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item_id[10:0], zero fill
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_id[10:0], ref_count[42:11], zero fill
   output logic [2:0]  rsp_tuser    // status[2:0]
);
   import ipfa_pkg::*;

   ctrl_cmd_type          cmd;
   dp_status_type         dp_status;
   logic [ID_BITS-1:0]    rsp_id;
   status_type            rsp_status;
   logic [RSP_CNT_BITS-1:0] rsp_count;

   // sequencer: clearing pass, accept, execute, response valid
   ipfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   // memories and pool registers
   ipfa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (dp_status),
      .req_mode   (req_tuser),
      .req_id     (req_tdata[ID_BITS-1:0]),
      .rsp_id     (rsp_id),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   // pack response word
   assign rsp_tdata = {{(RSP_DATA_BITS - ID_BITS - RSP_CNT_BITS){1'b0}}, rsp_count, rsp_id};
   assign rsp_tuser = rsp_status;

endmodule

// ===== rtl/ipfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipfa_ctrl
// sequencer: counter clearing pass, request accept, execute and response slot
// ----------------------------------------------------------------------------
module ipfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ipfa_pkg::dp_status_type status,
   output ipfa_pkg::ctrl_cmd_type  cmd
);
   import ipfa_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_BITS-1:0] clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept, fire;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && (state_ff == S_IDLE);
   // result slot must be free or emptying in this cycle, unless no result is due
   assign fire = (state_ff == S_EXEC) &&
                 (status.no_result || !rsp_valid_ff || rsp_tready);

   always_comb begin
      cmd.accept     = accept;
      cmd.exec       = fire;
      cmd.load_rsp   = fire && !status.no_result;
      cmd.clear_en   = (state_ff == S_CLEAR);
      cmd.clear_addr = clr_ff;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_BITS'(MAX_IDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (fire) begin
               state_in = S_IDLE;
               if (!status.no_result) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ipfa_datapath.sv =====
// ----------------------------------------------------------------------------
// ipfa_datapath
// free list link memory, reference counter memory, head and fresh counters
// ----------------------------------------------------------------------------
module ipfa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ipfa_pkg::ctrl_cmd_type        cmd,
   output ipfa_pkg::dp_status_type       status,
   input  logic [1:0]                    req_mode,
   input  logic [ipfa_pkg::ID_BITS-1:0]  req_id,
   output logic [ipfa_pkg::ID_BITS-1:0]  rsp_id,
   output ipfa_pkg::status_type          rsp_status,
   output logic [ipfa_pkg::RSP_CNT_BITS-1:0] rsp_count
);
   import ipfa_pkg::*;

   // link entries hold a head value, so one bit more than an index
   logic [IDX_BITS:0]   free_link_mem [MAX_IDS];
   logic [COUNT_BITS-1:0] use_count_mem [MAX_IDS];

   logic [IDX_BITS:0]     head_ff, head_in;
   logic [IDX_BITS:0]     fresh_ff, fresh_in;
   logic [1:0]            mode_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [IDX_BITS:0]     link_q_ff;
   logic [COUNT_BITS-1:0] cnt_q_ff;
   logic [ID_BITS-1:0]    rsp_id_ff;
   status_type            rsp_status_ff;
   logic [RSP_CNT_BITS-1:0] rsp_count_ff;

   logic                  id_ok, link_we, cnt_we;
   logic [IDX_BITS-1:0]   id_idx;
   logic [ID_BITS:0]      id_wide;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [ID_BITS-1:0]    res_id;
   status_type            res_st;
   logic [RSP_CNT_BITS-1:0] res_cnt;

   assign id_wide = {1'b0, id_ff};
   assign id_ok   = !id_ff[ID_BITS-1] && (id_wide < (ID_BITS+1)'(MAX_IDS));
   assign id_idx  = id_ff[IDX_BITS-1:0];
   assign status.no_result = (mode_ff == MODE_NONE);

   always_comb begin
      head_in   = head_ff;
      fresh_in  = fresh_ff;
      link_we   = 1'b0;
      cnt_we    = 1'b0;
      cnt_wdata = cnt_q_ff;
      res_id    = NONE_ID;
      res_st    = ST_EXHAUSTED;
      res_cnt   = '0;
      case (mode_ff)
         MODE_ASSIGN: begin
            if (head_ff < (IDX_BITS+1)'(MAX_IDS)) begin
               res_id  = ID_BITS'(head_ff);
               res_st  = ST_ASSIGNED;
               head_in = link_q_ff;
            end else if (fresh_ff < (IDX_BITS+1)'(MAX_IDS)) begin
               res_id   = ID_BITS'(fresh_ff);
               res_st   = ST_ASSIGNED;
               fresh_in = fresh_ff + 1'b1;
            end
         end
         MODE_RELEASE: begin
            res_st = ST_REL_IGNORED;
            if (id_ok && ({1'b0, id_idx} < fresh_ff)) begin
               link_we = 1'b1;
               head_in = {1'b0, id_idx};
               res_id  = id_ff;
               res_st  = ST_RELEASED;
            end
         end
         MODE_COUNT: begin
            res_st = ST_FALLBACK;
            if (id_ok) begin
               // saturate at all ones
               if (cnt_q_ff != COUNT_MAX) begin
                  cnt_wdata = cnt_q_ff + 1'b1;
               end
               cnt_we  = 1'b1;
               res_id  = id_ff;
               res_st  = ST_COUNTED;
               res_cnt = RSP_CNT_BITS'(cnt_wdata);
            end
         end
         default: res_st = ST_EXHAUSTED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= (IDX_BITS+1)'(MAX_IDS);
         fresh_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff   <= req_mode;
         id_ff     <= req_id;
         link_q_ff <= free_link_mem[head_ff[IDX_BITS-1:0]];
         cnt_q_ff  <= use_count_mem[req_id[IDX_BITS-1:0]];
      end
      if (cmd.exec && link_we) begin
         free_link_mem[id_idx] <= head_ff;
      end
      if (cmd.clear_en) begin
         use_count_mem[cmd.clear_addr] <= '0;
      end else if (cmd.exec && cnt_we) begin
         use_count_mem[id_idx] <= cnt_wdata;
      end
      if (cmd.load_rsp) begin
         rsp_id_ff     <= res_id;
         rsp_status_ff <= res_st;
         rsp_count_ff  <= res_cnt;
      end
   end

   assign rsp_id     = rsp_id_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== rtl/ipfa_checker.sv =====
// ----------------------------------------------------------------------------
// ipfa_checker
// port-level checks of the id pool allocator
// ----------------------------------------------------------------------------
module ipfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import ipfa_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // clearing pass blocks requests right after reset
   a_clear_block: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready during clearing pass");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // count field zero unless counted
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_COUNTED) |-> rsp_tdata[42:11] == '0)
      else $error("nonzero count on non-count response");

   // no-id statuses carry id -1
   a_none_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EXHAUSTED || rsp_tuser == ST_REL_IGNORED ||
                     rsp_tuser == ST_FALLBACK) |-> rsp_tdata[10:0] == NONE_ID)
      else $error("missing none id");

endmodule

bind id_pool_free_list_allocator_core ipfa_checker u_ipfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/tb_id_pool_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_id_pool_free_list_allocator_core
// self-checking bench for the id pool allocator: a directed opening, then a
// fill phase that drives the pool to exhaustion, then a mixed phase of
// assign, release and count traffic. Every response word is compared with a
// behavioral copy of the free list, fresh counter and reference counters.
// Both stream sides idle at random, and the bench adds one long response
// back-pressure and one drain pause on the request side.
// ----------------------------------------------------------------------------
module tb_id_pool_free_list_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ipfa_pkg::*;

   // words with a response, directed part included, before the run may stop
   localparam int ITEM_TARGET   = 1550;
   // exhausted responses wanted before leaving the fill phase
   localparam int EXHAUST_WANT  = 8;
   localparam int LONG_HOLD     = 80;
   localparam logic [ID_BITS-1:0] LIST_EMPTY = ID_BITS'(MAX_IDS);

   // one expected response word
   typedef struct packed {
      logic [ID_BITS-1:0]      id;
      status_type              status;
      logic [RSP_CNT_BITS-1:0] cnt;
   } rsp_word_t;

   // -------------------------------------------------------------------------
   // allocator state copy and response checker
   // -------------------------------------------------------------------------
   class id_pool_tracker;
      logic [ID_BITS-1:0]    links [MAX_IDS];
      logic [COUNT_BITS-1:0] counts [MAX_IDS];
      logic [ID_BITS-1:0]    head;
      logic [ID_BITS-1:0]    fresh;
      rsp_word_t             awaited [$];
      int                    errors;
      int                    exhausted_seen;

      function new();
         for (int i = 0; i < MAX_IDS; i++) begin
            links[i]  = '0;
            counts[i] = '0;
         end
         head           = LIST_EMPTY;
         fresh          = '0;
         errors         = 0;
         exhausted_seen = 0;
      endfunction

      // applies one accepted request; returns 1 and the word when it answers
      function bit note_request(input logic [1:0] mode, input logic [ID_BITS-1:0] raw,
                                output rsp_word_t w);
         logic [IDX_BITS-1:0] idx;
         idx   = raw[IDX_BITS-1:0];
         w.id  = NONE_ID;
         w.cnt = '0;
         case (mode)
            MODE_ASSIGN: begin
               if (head != LIST_EMPTY) begin
                  // pop the most recently released id
                  w.id     = head;
                  w.status = ST_ASSIGNED;
                  head     = links[head[IDX_BITS-1:0]];
               end else if (fresh < LIST_EMPTY) begin
                  w.id     = fresh;
                  w.status = ST_ASSIGNED;
                  fresh    = fresh + 1'b1;
               end else begin
                  w.status = ST_EXHAUSTED;
                  exhausted_seen++;
               end
            end
            MODE_RELEASE: begin
               // negative ids and ids never handed out are ignored
               if (raw[ID_BITS-1] || raw >= fresh) begin
                  w.status = ST_REL_IGNORED;
               end else begin
                  links[idx] = head;
                  head       = raw;
                  w.id       = raw;
                  w.status   = ST_RELEASED;
               end
            end
            MODE_COUNT: begin
               if (raw[ID_BITS-1]) begin
                  w.status = ST_FALLBACK;
               end else begin
                  if (counts[idx] != COUNT_MAX) counts[idx] = counts[idx] + 1'b1;
                  w.id     = raw;
                  w.status = ST_COUNTED;
                  w.cnt    = counts[idx][RSP_CNT_BITS-1:0];
               end
            end
            default: return 1'b0;
         endcase
         awaited.push_back(w);
         return 1'b1;
      endfunction

      function void check_response(input logic [ID_BITS-1:0] id, input logic [2:0] status,
                                   input logic [RSP_CNT_BITS-1:0] cnt);
         rsp_word_t w;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected word, id %0d status %0d count %0d",
                     $time, $signed(id), status, cnt);
            errors++;
            return;
         end
         w = awaited.pop_front();
         if (id !== w.id) begin
            $display("%0t: result_id mismatch, expected %0d, actual %0d",
                     $time, $signed(w.id), $signed(id));
            errors++;
         end
         if (status !== w.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, w.status, status);
            errors++;
         end
         if (cnt !== w.cnt) begin
            $display("%0t: ref_count mismatch, expected %0d, actual %0d",
                     $time, w.cnt, cnt);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // item_id[10:0], zero fill
   logic [1:0]  req_tuser  = MODE_NONE;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // result_id[10:0], ref_count[42:11], zero fill
   logic [2:0]  rsp_tuser;   // status[2:0]

   always #5 clock = ~clock;

   id_pool_free_list_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   id_pool_tracker     pool = new();
   // ids the bench believes are out in use, used to pick sensible releases
   logic [ID_BITS-1:0] held_ids [$];
   int                 answered    = 0;
   bit                 send_calm   = 1'b0;
   bit                 drain_ahead = 1'b0;

   // -------------------------------------------------------------------------
   // request side: one word per call, random gap in front of it
   // -------------------------------------------------------------------------
   task automatic issue(input logic [1:0] mode, input logic [ID_BITS-1:0] id);
      int        gap;
      int        hit;
      rsp_word_t w;
      // stretches with no idling now and then
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 3);
      if (drain_ahead && gap == 0) gap = 1;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // hold the request side until every response is back
         if (drain_ahead) begin
            while (pool.awaited.size() != 0) @(posedge clock);
            drain_ahead = 1'b0;
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS - ID_BITS){1'b0}}, id};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      if (pool.note_request(mode, id, w)) begin
         answered++;
         if (w.status == ST_ASSIGNED) begin
            held_ids.push_back(w.id);
         end else if (w.status == ST_RELEASED) begin
            hit = -1;
            for (int i = 0; i < held_ids.size(); i++)
               if (hit < 0 && held_ids[i] == w.id) hit = i;
            if (hit >= 0) held_ids.delete(hit);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // response side: checks every word, stalls at random after each one
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      int taken;
      bit calm;
      stall_left = 0;
      taken      = 0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            pool.check_response(rsp_tdata[ID_BITS-1:0], rsp_tuser,
                                rsp_tdata[ID_BITS +: RSP_CNT_BITS]);
            taken++;
            if ($urandom_range(0, 39) == 0) calm = !calm;
            stall_left = calm ? 0 : $urandom_range(0, 3);
            // one long back-pressure so the block fills and stalls its input
            if (taken == 300) stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int                 r;
      bit                 drain_done;
      logic [1:0]         mode;
      logic [ID_BITS-1:0] id;
      drain_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed opening: none ids, the most negative id, ids never handed
      // out, mode 3, lifo reuse and counts that survive a release
      issue(MODE_COUNT,   NONE_ID);
      issue(MODE_COUNT,   11'h400);
      issue(MODE_RELEASE, NONE_ID);
      issue(MODE_RELEASE, 11'h400);
      issue(MODE_RELEASE, 11'd0);
      issue(MODE_NONE,    11'h2aa);
      issue(MODE_ASSIGN,  11'h7ff);
      issue(MODE_ASSIGN,  11'h155);
      issue(MODE_ASSIGN,  11'd0);
      issue(MODE_RELEASE, 11'd3);
      issue(MODE_COUNT,   11'd0);
      issue(MODE_COUNT,   11'd0);
      issue(MODE_COUNT,   11'd1023);
      issue(MODE_RELEASE, 11'd1);
      issue(MODE_RELEASE, 11'd2);
      issue(MODE_ASSIGN,  11'd0);
      issue(MODE_ASSIGN,  11'd0);
      issue(MODE_ASSIGN,  11'd0);
      issue(MODE_RELEASE, 11'd0);
      issue(MODE_ASSIGN,  11'd0);
      issue(MODE_COUNT,   11'd0);
      issue(MODE_NONE,    NONE_ID);
      // counter saturation would take 2^32 increments, out of reach here

      // random part: assign-heavy until the pool runs dry, then mixed traffic
      while (answered < ITEM_TARGET || pool.exhausted_seen < EXHAUST_WANT) begin
         if (answered >= 900 && !drain_done) begin
            drain_ahead = 1'b1;
            drain_done  = 1'b1;
         end
         r  = $urandom_range(0, 99);
         id = ID_BITS'($urandom);
         if (pool.exhausted_seen < EXHAUST_WANT) begin
            // fill phase
            if (r < 90) mode = MODE_ASSIGN;
            else if (r < 95) begin
               mode = MODE_COUNT;
               if (held_ids.size() != 0) id = held_ids[$urandom_range(0, held_ids.size() - 1)];
            end else if (r < 98) begin
               mode = MODE_RELEASE;
               if (held_ids.size() != 0) id = held_ids[$urandom_range(0, held_ids.size() - 1)];
            end else if (r < 99) mode = MODE_RELEASE;
            else mode = MODE_NONE;
         end else begin
            // mixed phase
            if (r < 30 || (r < 58 && held_ids.size() == 0)) mode = MODE_ASSIGN;
            else if (r < 58) begin
               mode = MODE_RELEASE;
               id   = held_ids[$urandom_range(0, held_ids.size() - 1)];
            end else if (r < 80) begin
               mode = MODE_COUNT;
               if (held_ids.size() != 0) id = held_ids[$urandom_range(0, held_ids.size() - 1)];
               else id = ID_BITS'($urandom_range(0, MAX_IDS - 1));
            end else if (r < 85) mode = MODE_COUNT;
            else if (r < 90) mode = MODE_RELEASE;
            else if (r < 93) begin
               // any id in range, free and never handed out ones included
               mode = MODE_RELEASE;
               id   = ID_BITS'($urandom_range(0, MAX_IDS - 1));
            end else mode = MODE_NONE;
         end
         issue(mode, id);
      end
      req_tvalid <= 1'b0;

      // wait for the last responses, then for any stray words
      while (pool.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pool.awaited.size() != 0)
         $display("%0t: %0d expected words never arrived", $time, pool.awaited.size());
      if (pool.errors == 0 && pool.awaited.size() == 0) begin
         $display("tb_id_pool_free_list_allocator_core passed");
      end else begin
         $display("tb_id_pool_free_list_allocator_core failed");
      end
      $finish;
   end

   // watchdog, covers the clearing pass after reset with wide margin
   initial begin : watchdog
      #2000000;
      $display("tb_id_pool_free_list_allocator_core failed");
      $finish;
   end

endmodule
